>>> hw/rtl/bbc_pkg.sv
`default_nettype none

package bbc_pkg;

    localparam int COORD_W    = 8;
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 3;
    localparam int PIXEL_W    = CHAN_W * NUM_CHAN;
    localparam int WEIGHT_W   = 9;
    localparam int NUM_TAPS   = 4;
    localparam int PROD_W     = CHAN_W + WEIGHT_W;
    localparam int SUM_W      = PROD_W + 3;
    localparam int FRAC_W     = 8;

    localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(128);

    // Coverage map storage: one bit per tile position, packed into words.
    localparam int MAP_WORD_W = 32;
    localparam int WORD_SHIFT = 5;

    localparam int TILE_WIDTH_DEF  = 256;
    localparam int TILE_HEIGHT_DEF = 256;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_TL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_TR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_BL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_BR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTERP_MODE = 3'd4;

    localparam logic [WEIGHT_W-1:0] WEIGHT_TL_RESET = 9'd256;
    localparam logic [WEIGHT_W-1:0] WEIGHT_TR_RESET = 9'd0;
    localparam logic [WEIGHT_W-1:0] WEIGHT_BL_RESET = 9'd0;
    localparam logic [WEIGHT_W-1:0] WEIGHT_BR_RESET = 9'd0;
    localparam logic                INTERP_RESET    = 1'b1;

    // Tap order inside a lane: 0 top-left, 1 top-right, 2 bottom-left, 3 bottom-right
    typedef logic [NUM_TAPS-1:0][CHAN_W-1:0]   sample_set_t;
    typedef logic [NUM_TAPS-1:0][WEIGHT_W-1:0] weight_set_t;
    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0]   chan_set_t;

    typedef struct packed {
        logic load_prod;
        logic load_sum;
    } bbc_lane_ctl_t;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [PIXEL_W-1:0] tl_pixel;
        logic               written;
    } bbc_meta_t;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [PIXEL_W-1:0] pixel;
        logic               written;
    } bbc_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/bbc_in_if.sv
`default_nettype none

interface bbc_in_if;
    import bbc_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [PIXEL_W-1:0] top_left_pixel;
    logic [PIXEL_W-1:0] top_right_pixel;
    logic [PIXEL_W-1:0] bottom_left_pixel;
    logic [PIXEL_W-1:0] bottom_right_pixel;

    modport source (
        output valid, column, row, top_left_pixel, top_right_pixel,
               bottom_left_pixel, bottom_right_pixel,
        input  ready
    );

    modport sink (
        input  valid, column, row, top_left_pixel, top_right_pixel,
               bottom_left_pixel, bottom_right_pixel,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/bbc_out_if.sv
`default_nettype none

interface bbc_out_if;
    import bbc_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] out_column;
    logic [COORD_W-1:0] out_row;
    logic [PIXEL_W-1:0] out_pixel;
    logic               written;

    modport source (
        output valid, out_column, out_row, out_pixel, written,
        input  ready
    );

    modport sink (
        input  valid, out_column, out_row, out_pixel, written,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/bbc_cfg_if.sv
`default_nettype none

interface bbc_cfg_if;
    import bbc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/bbc_lane.sv
`default_nettype none

// One color channel: four products, then rounded sum.
module bbc_lane
    import bbc_pkg::*;
(
    input  logic                clk,
    input  bbc_lane_ctl_t       ctl,
    input  sample_set_t         sample,
    input  weight_set_t         weight,
    output logic [CHAN_W-1:0]   chan
);

    logic [NUM_TAPS-1:0][PROD_W-1:0] prod_reg;
    logic [NUM_TAPS-1:0][PROD_W-1:0] prod_next;
    logic [SUM_W-1:0]                sum;
    logic [CHAN_W-1:0]               chan_reg;
    logic [CHAN_W-1:0]               chan_next;

    always_comb
    begin
        for (int t = 0; t < NUM_TAPS; t++)
        begin
            prod_next[t] = PROD_W'(sample[t]) * PROD_W'(weight[t]);
        end
    end

    always_comb
    begin
        sum = ROUND_BIAS;
        for (int t = 0; t < NUM_TAPS; t++)
        begin
            sum = sum + SUM_W'(prod_reg[t]);
        end
        // keep the low byte above the fraction
        chan_next = sum[FRAC_W +: CHAN_W];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_prod)
        begin
            prod_reg <= prod_next;
        end
        if (ctl.load_sum)
        begin
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

`default_nettype wire

>>> hw/rtl/bbc_cov.sv
`default_nettype none

// Coverage bitmap: word-wide RAM with read-modify-write and a bypass of the
// most recent write. Sweeps the RAM to zero after reset.
module bbc_cov
    import bbc_pkg::*;
#(
    parameter int TILE_WIDTH  = TILE_WIDTH_DEF,
    parameter int TILE_HEIGHT = TILE_HEIGHT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               lookup,
    input  logic [COORD_W-1:0] column,
    input  logic [COORD_W-1:0] row,
    input  logic               commit,
    output logic               fresh,
    output logic               busy
);

    localparam int MAP_BITS  = TILE_WIDTH * TILE_HEIGHT;
    localparam int MAP_WORDS = (MAP_BITS + MAP_WORD_W - 1) / MAP_WORD_W;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int POS_W     = ADDR_W + WORD_SHIFT;

    logic [MAP_WORD_W-1:0] mem [MAP_WORDS];

    logic [POS_W-1:0]      pos;
    logic                  in_range;
    logic [ADDR_W-1:0]     lk_addr;

    logic [ADDR_W-1:0]     addr_reg;
    logic [WORD_SHIFT-1:0] bit_reg;
    logic                  in_range_reg;
    logic [MAP_WORD_W-1:0] rd_data_reg;

    logic                  lw_valid_reg;
    logic [ADDR_W-1:0]     lw_addr_reg;
    logic [MAP_WORD_W-1:0] lw_data_reg;

    logic                  clr_busy_reg;
    logic [ADDR_W-1:0]     clr_addr_reg;

    logic [MAP_WORD_W-1:0] cur_word;
    logic                  wr_en;
    logic                  upd_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [MAP_WORD_W-1:0] wr_data;
    logic [MAP_WORD_W-1:0] upd_word;

    always_comb
    begin
        pos      = POS_W'(32'(row) * 32'(TILE_WIDTH) + 32'(column));
        in_range = (32'(column) < 32'(TILE_WIDTH)) && (32'(row) < 32'(TILE_HEIGHT));
        lk_addr  = ADDR_W'(pos >> WORD_SHIFT);
    end

    // the write issued on the lookup edge is missing from rd_data_reg
    always_comb
    begin
        if (lw_valid_reg && (lw_addr_reg == addr_reg))
        begin
            cur_word = lw_data_reg;
        end
        else
        begin
            cur_word = rd_data_reg;
        end
        fresh    = in_range_reg && !cur_word[bit_reg];
        upd_word = cur_word | (MAP_WORD_W'(1) << bit_reg);
        upd_en   = commit && fresh;
        wr_en    = clr_busy_reg || upd_en;
        wr_addr  = clr_busy_reg ? clr_addr_reg : addr_reg;
        wr_data  = clr_busy_reg ? '0 : upd_word;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (lookup)
        begin
            rd_data_reg  <= mem[lk_addr];
            addr_reg     <= lk_addr;
            bit_reg      <= pos[WORD_SHIFT-1:0];
            in_range_reg <= in_range;
        end
        if (upd_en)
        begin
            lw_addr_reg <= addr_reg;
            lw_data_reg <= upd_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(MAP_WORDS - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (upd_en)
            begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    assign busy = clr_busy_reg;

endmodule

`default_nettype wire

>>> hw/rtl/bbc_merge.sv
`default_nettype none

// Combine lanes (or take top-left/zero) into the pixel in the output register.
module bbc_merge
    import bbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  bbc_meta_t   meta,
    input  logic        mode,
    input  chan_set_t   chan,
    input  logic        take,
    output logic        free,
    output logic        valid,
    output bbc_result_t result
);

    logic        valid_reg;
    bbc_result_t result_reg;
    bbc_result_t result_next;

    always_comb
    begin
        result_next.column  = meta.column;
        result_next.row     = meta.row;
        result_next.written = meta.written;
        if (!meta.written)
        begin
            result_next.pixel = '0;
        end
        else if (mode)
        begin
            result_next.pixel = {chan[2], chan[1], chan[0]};
        end
        else
        begin
            result_next.pixel = meta.tl_pixel;
        end
    end

    assign free = !valid_reg || take;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign valid  = valid_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

>>> hw/rtl/bilinear_rgb_blend_with_coverage.sv
// An accepted input word moves through stage 1, stage 2 and the output register in turn.
// Throughput: one word per cycle while pix_out.ready holds and no clearing pass runs;
// the coverage RAM takes one read and one write a cycle. Reset: weights go to 256/0/0/0,
// interpolate mode to 1; a clearing pass then zeroes the RAM one 32-bit word a cycle,
// over ceil(TILE_WIDTH*TILE_HEIGHT/32) words (2048 at 256x256), taking no input word.
`default_nettype none

module bilinear_rgb_blend_with_coverage
    import bbc_pkg::*;
#(
    parameter int TILE_WIDTH  = TILE_WIDTH_DEF,
    parameter int TILE_HEIGHT = TILE_HEIGHT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    bbc_in_if.sink     pix_in,
    bbc_out_if.source  pix_out,
    bbc_cfg_if.sink    cfg
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [WEIGHT_W-1:0] weight_tl_reg;
    logic [WEIGHT_W-1:0] weight_tr_reg;
    logic [WEIGHT_W-1:0] weight_bl_reg;
    logic [WEIGHT_W-1:0] weight_br_reg;
    logic                interp_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_tl_reg <= WEIGHT_TL_RESET;
            weight_tr_reg <= WEIGHT_TR_RESET;
            weight_bl_reg <= WEIGHT_BL_RESET;
            weight_br_reg <= WEIGHT_BR_RESET;
            interp_reg    <= INTERP_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_WEIGHT_TL:   weight_tl_reg <= cfg.data[WEIGHT_W-1:0];
                REG_WEIGHT_TR:   weight_tr_reg <= cfg.data[WEIGHT_W-1:0];
                REG_WEIGHT_BL:   weight_bl_reg <= cfg.data[WEIGHT_W-1:0];
                REG_WEIGHT_BR:   weight_br_reg <= cfg.data[WEIGHT_W-1:0];
                REG_INTERP_MODE: interp_reg    <= cfg.data[0];
                default:         ;  // drop writes past the register list
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline control
    //   stage 1: coverage word read, lane products
    //   stage 2: coverage decision / RAM update, lane sums
    //   stage 3: merged pixel in the output register
    // Each stage advances on its own, so a bubble anywhere is filled even
    // while the output word waits to be taken.
    // ---------------------------------------------------------------
    logic          s1_valid_reg;
    logic          s2_valid_reg;
    bbc_meta_t     s1_meta_reg;
    bbc_meta_t     s2_meta_reg;
    bbc_meta_t     s1_meta_next;
    bbc_meta_t     s2_meta_next;

    logic          accept;
    logic          s1_adv;
    logic          s1_free;
    logic          s2_adv;
    logic          s2_free;
    logic          out_free;

    logic          cov_fresh;
    logic          cov_busy;

    bbc_lane_ctl_t lane_ctl;
    weight_set_t   lane_weight;
    chan_set_t     lane_chan;
    bbc_result_t   result;
    logic          out_valid;

    assign s2_adv  = s2_valid_reg && out_free;
    assign s2_free = !s2_valid_reg || s2_adv;
    assign s1_adv  = s1_valid_reg && s2_free;
    assign s1_free = !s1_valid_reg || s1_adv;

    // hold off input while the coverage RAM is being swept
    assign pix_in.ready = s1_free && !cov_busy;
    assign accept       = pix_in.valid && pix_in.ready;

    always_comb
    begin
        s1_meta_next.column   = pix_in.column;
        s1_meta_next.row      = pix_in.row;
        s1_meta_next.tl_pixel = pix_in.top_left_pixel;
        s1_meta_next.written  = 1'b0;

        s2_meta_next          = s1_meta_reg;
        s2_meta_next.written  = cov_fresh;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_meta_reg <= s1_meta_next;
        end
        if (s1_adv)
        begin
            s2_meta_reg <= s2_meta_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Coverage map: looked up on accept, marked when stage 1 advances
    // ---------------------------------------------------------------
    bbc_cov #(
        .TILE_WIDTH  (TILE_WIDTH),
        .TILE_HEIGHT (TILE_HEIGHT)
    ) u_cov (
        .clk    (clk),
        .rst_n  (rst_n),
        .lookup (accept),
        .column (pix_in.column),
        .row    (pix_in.row),
        .commit (s1_adv),
        .fresh  (cov_fresh),
        .busy   (cov_busy)
    );

    // ---------------------------------------------------------------
    // Channel lanes: R, G, B in parallel
    // ---------------------------------------------------------------
    assign lane_ctl.load_prod = accept;
    assign lane_ctl.load_sum  = s1_adv;

    assign lane_weight[0] = weight_tl_reg;
    assign lane_weight[1] = weight_tr_reg;
    assign lane_weight[2] = weight_bl_reg;
    assign lane_weight[3] = weight_br_reg;

    for (genvar ch = 0; ch < NUM_CHAN; ch++)
    begin : g_lane
        sample_set_t lane_sample;

        assign lane_sample[0] = pix_in.top_left_pixel[ch*CHAN_W +: CHAN_W];
        assign lane_sample[1] = pix_in.top_right_pixel[ch*CHAN_W +: CHAN_W];
        assign lane_sample[2] = pix_in.bottom_left_pixel[ch*CHAN_W +: CHAN_W];
        assign lane_sample[3] = pix_in.bottom_right_pixel[ch*CHAN_W +: CHAN_W];

        bbc_lane u_lane (
            .clk    (clk),
            .ctl    (lane_ctl),
            .sample (lane_sample),
            .weight (lane_weight),
            .chan   (lane_chan[ch])
        );
    end

    // ---------------------------------------------------------------
    // Merge and output register
    // ---------------------------------------------------------------
    bbc_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (s2_adv),
        .meta   (s2_meta_reg),
        .mode   (interp_reg),
        .chan   (lane_chan),
        .take   (pix_out.ready),
        .free   (out_free),
        .valid  (out_valid),
        .result (result)
    );

    assign pix_out.valid      = out_valid;
    assign pix_out.out_column = result.column;
    assign pix_out.out_row    = result.row;
    assign pix_out.out_pixel  = result.pixel;
    assign pix_out.written    = result.written;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------

    // A position marked by the word just ahead must read back as covered.
    a_bypass_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s2_valid_reg && s2_meta_reg.written &&
         (s2_meta_reg.column == s1_meta_reg.column) &&
         (s2_meta_reg.row == s1_meta_reg.row)) |-> !cov_fresh)
        else $error("covered position reported fresh");

    // A word that is not written carries a zero pixel.
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_out.valid && !pix_out.written) |-> (pix_out.out_pixel == '0))
        else $error("skipped word carries a pixel");

    // Only positions inside the tile are ever written.
    a_in_tile: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_out.valid && pix_out.written) |->
        ((32'(pix_out.out_column) < 32'(TILE_WIDTH)) &&
         (32'(pix_out.out_row) < 32'(TILE_HEIGHT))))
        else $error("written word outside tile");

    // The pipeline is empty when the clearing pass ends.
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(cov_busy) |-> (!s1_valid_reg && !s2_valid_reg && !out_valid))
        else $error("word entered during coverage clear");

endmodule

`default_nettype wire
